FILE: hw/rtl/n_queens_solution_enumerator_defines.svh
// Assertion helpers shared by the RTL that checks itself.
// Both sample on the rising clock edge and stay quiet while reset is high.
`ifndef N_QUEENS_SOLUTION_ENUMERATOR_DEFINES_SVH
`define N_QUEENS_SOLUTION_ENUMERATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NQSE_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NQSE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/nqse_pkg.sv
`timescale 1ns / 1ps

package nqse_pkg;

   localparam int BOARD_W    = 5;
   localparam int COL_W      = 4;
   localparam int CNT_W      = 24;
   localparam int CELL_W     = 8;
   localparam int NSQ_W      = 9;
   localparam int PLACE_ROWS = 16;
   localparam int PLACE_W    = PLACE_ROWS * COL_W;

   localparam logic [CNT_W-1:0]   CNT_MAX     = 24'hFF_FFFF;
   localparam logic [BOARD_W-1:0] BOARD_RESET = 5'd8;
   localparam logic [NSQ_W-1:0]   NSQ_RESET   = 9'd64;

   typedef enum logic [1:0] {
      REQ_RESTART = 2'd0,
      REQ_NEXT    = 2'd1,
      REQ_READ    = 2'd2
   } req_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_HIST_RD,
      ST_HIST_WR,
      ST_READ_WAIT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [CELL_W-1:0] cell_index;
   } request_type;

   typedef struct packed {
      logic               found;
      logic               exhausted;
      logic [PLACE_W-1:0] placement;
      logic [CNT_W-1:0]   solution_count;
      logic [CNT_W-1:0]   cell_count;
   } response_type;

   typedef struct packed {
      logic clear;
      logic rd_en;
      logic wr_en;
   } hist_ctl_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] value);
      sat_inc = (value == CNT_MAX) ? value : value + 1'b1;
   endfunction

endpackage

FILE: hw/rtl/nqse_check.sv
`timescale 1ns / 1ps

module nqse_check import nqse_pkg::*; #(
   parameter int MAX_BOARD = 16
) (
   input  logic [MAX_BOARD-1:0][COL_W-1:0] stack,
   input  logic [BOARD_W-1:0]              row,
   input  logic [COL_W-1:0]                col,
   output logic                            safe
);

   logic [MAX_BOARD-1:0] hit;

   // Compare the candidate column against every queen already placed above it.
   always_comb begin
      logic [COL_W-1:0]   diff;
      logic [BOARD_W-1:0] gap;
      diff = '0;
      gap  = '0;
      hit  = '0;
      for (int i = 0; i < MAX_BOARD; i++) begin
         diff   = (stack[i] > col) ? (stack[i] - col) : (col - stack[i]);
         gap    = row - BOARD_W'(i);
         hit[i] = (BOARD_W'(i) < row) && ((diff == '0) || ({1'b0, diff} == gap));
      end
   end

   assign safe = ~|hit;

endmodule

FILE: hw/rtl/nqse_hist.sv
`timescale 1ns / 1ps

module nqse_hist import nqse_pkg::*; #(
   parameter int MAX_BOARD = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  hist_ctl_type                                  ctl,
   input  logic [$clog2(MAX_BOARD*MAX_BOARD)-1:0]        rd_addr,
   input  logic [$clog2(MAX_BOARD*MAX_BOARD)-1:0]        wr_addr,
   input  logic [CNT_W-1:0]                              wr_data,
   output logic [CNT_W-1:0]                              rd_data
);

   localparam int DEPTH = MAX_BOARD * MAX_BOARD;

   logic [CNT_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [CNT_W-1:0] rd_data_ff;
   logic             rd_vld_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // Drop all entries at once on restart; an entry never written reads as zero.
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

FILE: hw/rtl/n_queens_solution_enumerator.sv
// N-queens solution enumerator: depth-first search over a column stack.
// Request channel: drive req_data with start high; the item is taken on the
// rising edge where start is high and busy is low. busy stays high until the
// result has been shown. Result channel: rsp_valid is high for exactly one
// cycle with rsp_data; the receiver cannot stall it, so it must take it then.
// Register csr_wdata (board size) is written when csr_we is high, clamped to
// 1..MAX_BOARD, and restarts the search; write it only while busy is low.
// Path from accept to the result strobe:
//   restart, unused code, off-board read or next after exhaustion go
//   straight to the result; a histogram read on the board first waits for
//   the histogram read data; a next request runs the search steps (one
//   candidate column or one backtrack per cycle through the shared
//   conflict checker), then a read-modify-write of the histogram cell of
//   each row, one cell at a time; no histogram pass when the search runs out.
//   After a result, busy drops in the following cycle, so the next item may
//   be given then.
// Reset: board size 8 (MAX_BOARD if smaller), empty stack, solution count zero,
// histogram reads as zero (per-cell valid bits, no clearing pass).
`timescale 1ns / 1ps
`include "n_queens_solution_enumerator_defines.svh"

module n_queens_solution_enumerator import nqse_pkg::*; #(
   parameter int MAX_BOARD = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  request_type        req_data,
   output logic               rsp_valid,
   output response_type       rsp_data,
   input  logic               csr_we,
   input  logic [BOARD_W-1:0] csr_wdata
);

   localparam int ROW_IW     = $clog2(MAX_BOARD);
   localparam int HIST_DEPTH = MAX_BOARD * MAX_BOARD;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);

   localparam logic [BOARD_W-1:0] BOARD_MAX  = BOARD_W'(MAX_BOARD);
   localparam logic [BOARD_W-1:0] BOARD_INIT = (BOARD_RESET > BOARD_MAX) ? BOARD_MAX :
                                               BOARD_RESET;
   localparam logic [NSQ_W-1:0]   NSQ_INIT   = (BOARD_RESET > BOARD_MAX) ?
                                               NSQ_W'(MAX_BOARD * MAX_BOARD) : NSQ_RESET;

   state_type                       state_ff, state_in;
   logic [BOARD_W-1:0]              row_ff, row_in;
   logic [BOARD_W-1:0]              col_ff, col_in;
   logic [MAX_BOARD-1:0][COL_W-1:0] stack_ff, stack_in;
   logic                            done_ff, done_in;
   logic [CNT_W-1:0]                total_ff, total_in;
   logic [BOARD_W-1:0]              board_ff, board_in;
   logic [NSQ_W-1:0]                nsq_ff, nsq_in;
   logic                            found_ff, found_in;
   logic                            exh_ff, exh_in;
   logic [CNT_W-1:0]                cell_ff, cell_in;
   logic [ROW_IW-1:0]               rr_ff, rr_in;
   logic [HIST_AW-1:0]              base_ff, base_in;
   logic [HIST_AW-1:0]              addr_ff, addr_in;

   logic [BOARD_W-1:0]   row_dec;
   logic [BOARD_W-1:0]   last_row;
   logic                 col_lt_n;
   logic [ROW_IW-1:0]    stk_sel;
   logic [COL_W-1:0]     stack_rd;
   logic                 safe;
   logic [HIST_AW-1:0]   rec_addr;
   logic [HIST_AW-1:0]   hist_rd_addr;
   logic [CNT_W-1:0]     hist_rd_data;
   hist_ctl_type         hctl;
   logic                 restart;
   logic [BOARD_W-1:0]   csr_clamp;
   logic [2*BOARD_W-1:0] csr_sq;
   logic [PLACE_W-1:0]   placement;

   assign row_dec  = row_ff - 5'd1;
   assign last_row = board_ff - 5'd1;
   assign col_lt_n = col_ff < board_ff;
   assign stack_rd = stack_ff[stk_sel];
   assign rec_addr = base_ff + HIST_AW'(stack_rd);

   assign csr_clamp = (csr_wdata == '0) ? 5'd1 :
                      (csr_wdata > BOARD_MAX) ? BOARD_MAX : csr_wdata;
   assign csr_sq    = {{BOARD_W{1'b0}}, csr_clamp} * {{BOARD_W{1'b0}}, csr_clamp};

   nqse_check #(
      .MAX_BOARD (MAX_BOARD)
   ) u_check (
      .stack (stack_ff),
      .row   (row_ff),
      .col   (col_ff[COL_W-1:0]),
      .safe  (safe)
   );

   nqse_hist #(
      .MAX_BOARD (MAX_BOARD)
   ) u_hist (
      .clock   (clock),
      .reset   (reset),
      .ctl     (hctl),
      .rd_addr (hist_rd_addr),
      .wr_addr (addr_ff),
      .wr_data (sat_inc(hist_rd_data)),
      .rd_data (hist_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      stack_in     = stack_ff;
      done_in      = done_ff;
      total_in     = total_ff;
      board_in     = board_ff;
      nsq_in       = nsq_ff;
      found_in     = found_ff;
      exh_in       = exh_ff;
      cell_in      = cell_ff;
      rr_in        = rr_ff;
      base_in      = base_ff;
      addr_in      = addr_ff;
      hctl         = '0;
      hist_rd_addr = rec_addr;
      stk_sel      = row_dec[ROW_IW-1:0];
      restart      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            stk_sel      = last_row[ROW_IW-1:0];
            hist_rd_addr = req_data.cell_index[HIST_AW-1:0];
            if (start) begin
               found_in = 1'b0;
               exh_in   = 1'b0;
               cell_in  = '0;
               state_in = ST_RESP;
               case (req_data.req_type)
                  REQ_RESTART: begin
                     restart = 1'b1;
                  end
                  REQ_NEXT: begin
                     if (done_ff) begin
                        exh_in = 1'b1;
                     end else begin
                        state_in = ST_SEARCH;
                        // Resume past the last reported solution; otherwise start the row at column zero.
                        if (row_ff >= board_ff) begin
                           row_in = last_row;
                           col_in = {1'b0, stack_rd} + 5'd1;
                        end else begin
                           col_in = '0;
                        end
                     end
                  end
                  REQ_READ: begin
                     exh_in = done_ff;
                     if ({1'b0, req_data.cell_index} < nsq_ff) begin
                        hctl.rd_en = 1'b1;
                        state_in   = ST_READ_WAIT;
                     end
                  end
                  default: begin
                     exh_in = done_ff;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (col_lt_n) begin
               if (!safe) begin
                  col_in = col_ff + 5'd1;
               end else begin
                  stack_in[row_ff[ROW_IW-1:0]] = col_ff[COL_W-1:0];
                  if (row_ff + 5'd1 == board_ff) begin
                     row_in   = board_ff;
                     found_in = 1'b1;
                     total_in = sat_inc(total_ff);
                     rr_in    = '0;
                     base_in  = '0;
                     state_in = ST_HIST_RD;
                  end else begin
                     row_in = row_ff + 5'd1;
                     col_in = '0;
                  end
               end
            end else if (row_ff == '0) begin
               done_in  = 1'b1;
               exh_in   = 1'b1;
               state_in = ST_RESP;
            end else begin
               // Backtrack one row and try the next column there.
               row_in = row_dec;
               col_in = {1'b0, stack_rd} + 5'd1;
            end
         end
         ST_HIST_RD: begin
            stk_sel    = rr_ff;
            addr_in    = rec_addr;
            hctl.rd_en = 1'b1;
            state_in   = ST_HIST_WR;
         end
         ST_HIST_WR: begin
            hctl.wr_en = 1'b1;
            if (BOARD_W'(rr_ff) + 5'd1 == board_ff) begin
               state_in = ST_RESP;
            end else begin
               rr_in    = rr_ff + 1'b1;
               base_in  = base_ff + HIST_AW'(board_ff);
               state_in = ST_HIST_RD;
            end
         end
         ST_READ_WAIT: begin
            cell_in  = hist_rd_data;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         board_in = csr_clamp;
         nsq_in   = csr_sq[NSQ_W-1:0];
         restart  = 1'b1;
      end

      if (restart) begin
         row_in     = '0;
         done_in    = 1'b0;
         total_in   = '0;
         stack_in   = '0;
         hctl.clear = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         done_ff  <= 1'b0;
         total_ff <= '0;
         board_ff <= BOARD_INIT;
         nsq_ff   <= NSQ_INIT;
         found_ff <= 1'b0;
         exh_ff   <= 1'b0;
         stack_ff <= '0;
      end else begin
         row_ff   <= row_in;
         done_ff  <= done_in;
         total_ff <= total_in;
         board_ff <= board_in;
         nsq_ff   <= nsq_in;
         found_ff <= found_in;
         exh_ff   <= exh_in;
         stack_ff <= stack_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff  <= col_in;
      cell_ff <= cell_in;
      rr_ff   <= rr_in;
      base_ff <= base_in;
      addr_ff <= addr_in;
   end

   // Rows beyond the board, and all rows while no solution is found, read as zero.
   always_comb begin
      placement = '0;
      for (int r = 0; r < MAX_BOARD; r++) begin
         if (found_ff && (BOARD_W'(r) < board_ff)) begin
            placement[r*COL_W +: COL_W] = stack_ff[r];
         end
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

   assign rsp_data.found          = found_ff;
   assign rsp_data.exhausted      = exh_ff;
   assign rsp_data.placement      = placement;
   assign rsp_data.solution_count = total_ff;
   assign rsp_data.cell_count     = cell_ff;

   `NQSE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
   `NQSE_ASSERT_SAME(a_found_excl, rsp_valid, !(found_ff && exh_ff), "found with exhausted")
   `NQSE_ASSERT_SAME(a_row_bound, !busy, row_ff <= board_ff, "search row beyond board")
   `NQSE_ASSERT_SAME(a_found_count, rsp_valid && found_ff, total_ff != '0, "count is zero")

endmodule
